FILE: rtl/core/fsp_pkg.sv
// Shared types, constants and helpers of the fixed-size packet framer and batcher.
package fsp_pkg;

   localparam int PAYLOAD_BYTES = 1006;
   localparam int HEADER_BYTES  = 18;
   localparam int PACKET_BYTES  = PAYLOAD_BYTES + HEADER_BYTES;

   localparam int POS_W      = $clog2(PAYLOAD_BYTES + 1);
   localparam int HDR_IDX_W  = $clog2(HEADER_BYTES + 1);
   localparam int BATCH_MAX  = 1024;
   localparam int CNT_W      = 10;
   localparam int LIMIT_W    = 11;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] SYNC_HI = 8'hEB;
   localparam logic [7:0] SYNC_LO = 8'h90;

   localparam logic [47:0]        DEST_RESET     = 48'h000000102005;
   localparam logic [47:0]        SOURCE_RESET   = 48'h000000000002;
   localparam logic [15:0]        PRIORITY_RESET = 16'h0001;
   localparam logic [LIMIT_W-1:0] BATCH_RESET    = LIMIT_W'(BATCH_MAX);

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_PAD   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST     = 2'd0,
      CSR_SOURCE   = 2'd1,
      CSR_PRIORITY = 2'd2,
      CSR_BATCH    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       packet_end;
      logic       batch_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        dest_address;
      logic [47:0]        source_address;
      logic [15:0]        priority_field;
      logic [LIMIT_W-1:0] batch_packets;
   } cfg_type;

   // One queued request for the back end: optional header, then one byte.
   typedef struct packed {
      logic       hdr;
      logic [7:0] data;
      logic       pend;
      logic       bend;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [LIMIT_W-1:0] batch_limit(input logic [LIMIT_W-1:0] b);
      logic [LIMIT_W-1:0] lim;
      if (b == '0) begin
         lim = LIMIT_W'(1);
      end else if (b > LIMIT_W'(BATCH_MAX)) begin
         lim = LIMIT_W'(BATCH_MAX);
      end else begin
         lim = b;
      end
      return lim;
   endfunction

   function automatic logic [7:0] header_byte(input logic [HDR_IDX_W-1:0] idx,
                                              input cfg_type cfg);
      logic [HEADER_BYTES-1:0][7:0] hdr;
      logic [HDR_IDX_W-1:0]         rev;
      hdr = {SYNC_HI, SYNC_LO, 16'(PACKET_BYTES), cfg.dest_address,
             cfg.source_address, cfg.priority_field};
      rev = HDR_IDX_W'(HEADER_BYTES - 1) - idx;
      return hdr[rev];
   endfunction

endpackage

FILE: rtl/core/fixed_size_packet_framer_batcher.sv
// Top level of the fixed-size packet framer and batcher.
//
// Requests (req_*) carry a kind and a payload byte. A payload byte opens a
// packet if none is open; then the 18-byte header (sync, length, destination,
// source, priority) goes out ahead of it. Pad adds a zero byte only inside an
// open packet; clear drops the open packet and zeroes the batch count.
// Responses (rsp_*) are one framed byte each, with packet end, batch end and
// a flag on the last byte caused by a request.
// User writes registers via csr_we/csr_index/csr_wdata only while idle; unchecked.
// Throughput: one request per cycle while the queue has room; a packet-opening
// request holds the output for its header and payload byte, every other byte
// alone. The output register and the header sequencer set this rate; a
// four-entry command queue lets requests keep arriving while a header drains.
// A response passes the command queue and then the output register.
// Reset: no packet open, batch count zero, registers at defaults, queue empty.
// When the receiver stalls, the output holds, the queue fills, then req_ready
// drops until room frees up.
module fixed_size_packet_framer_batcher
   import fsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   cmd_type      cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         push;
   logic         pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST:     cfg_in.dest_address   = csr_wdata;
            CSR_SOURCE:   cfg_in.source_address = csr_wdata;
            CSR_PRIORITY: cfg_in.priority_field = csr_wdata[15:0];
            CSR_BATCH:    cfg_in.batch_packets  = csr_wdata[LIMIT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_address   <= DEST_RESET;
         cfg_ff.source_address <= SOURCE_RESET;
         cfg_ff.priority_field <= PRIORITY_RESET;
         cfg_ff.batch_packets  <= BATCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .cmd       (cmd)
   );

   fsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   fsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/fsp_front.sv
// Front end: accepts requests, tracks packet and batch position, issues commands.
module fsp_front
   import fsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      cmd
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_inc;
   logic [LIMIT_W-1:0] cnt_inc;
   logic               accept;
   logic               emit;
   kind_type           kind;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign kind      = kind_type'(req_data.kind);
   assign pos_inc   = pos_ff + POS_W'(1);
   assign cnt_inc   = {1'b0, cnt_ff} + LIMIT_W'(1);

   always_comb begin
      emit     = 1'b0;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      cmd.hdr  = (pos_ff == '0);
      cmd.data = (kind == KIND_DATA) ? req_data.payload_byte : 8'h00;
      cmd.pend = 1'b0;
      cmd.bend = 1'b0;
      if (accept) begin
         unique case (kind)
            KIND_DATA:  emit = 1'b1;
            KIND_PAD:   emit = (pos_ff != '0);
            KIND_CLEAR: begin
               pos_in = '0;
               cnt_in = '0;
            end
            KIND_NONE:  emit = 1'b0;
            default:    emit = 1'b0;
         endcase
      end
      if (emit) begin
         if (pos_inc >= POS_W'(PAYLOAD_BYTES)) begin
            cmd.pend = 1'b1;
            pos_in   = '0;
            if (cnt_inc >= batch_limit(cfg.batch_packets)) begin
               cmd.bend = 1'b1;
               cnt_in   = '0;
            end else begin
               cnt_in = CNT_W'(cnt_inc);
            end
         end else begin
            pos_in = pos_inc;
         end
      end
   end

   assign push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/fsp_queue.sv
// Short command queue between front and back end.
module fsp_queue
   import fsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/fsp_back.sv
// Back end: expands commands into header and payload bytes, output register.
module fsp_back
   import fsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   rsp_type              data_ff, data_in;
   logic                 load;
   logic                 in_header;

   assign load      = !valid_ff || rsp_ready;
   assign in_header = head.hdr && (idx_ff < HDR_IDX_W'(HEADER_BYTES));

   always_comb begin
      pop      = 1'b0;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (in_header) begin
               data_in.stream_byte = header_byte(idx_ff, cfg);
               data_in.packet_end  = 1'b0;
               data_in.batch_end   = 1'b0;
               data_in.run_last    = 1'b0;
               idx_in              = idx_ff + HDR_IDX_W'(1);
            end else begin
               data_in.stream_byte = head.data;
               data_in.packet_end  = head.pend;
               data_in.batch_end   = head.bend;
               data_in.run_last    = 1'b1;
               idx_in              = '0;
               pop                 = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/fsp_checker.sv
// Port-level checks for the framer and batcher, bound to the top level.
module fsp_checker
   import fsp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_batch_on_packet_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.batch_end |-> rsp_data.packet_end)
      else $error("batch end without packet end");

   a_packet_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |-> rsp_data.run_last)
      else $error("packet end on a header byte");

endmodule

bind fixed_size_packet_framer_batcher fsp_checker u_fsp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
